// ===== src/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by spq_store, spq_seq and sorted_priority_queue; depends on nothing.
`timescale 1ns / 1ps

package spq_pkg;

    // Default number of slots
    localparam int SPQ_DEPTH = 8;

    localparam int DATA_W = 32;
    localparam int PRIO_W = 8;

    // Request kinds carried on s_tuser
    typedef enum logic {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } req_t;

    // Result status carried on m_tuser
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // One stored slot
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } entry_t;

    // Accepted request handed to the sequencer
    typedef struct packed {
        req_t              kind;
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
    } spq_req_t;

    // Finished result handed back to the output register
    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] data;
    } spq_result_t;

endpackage

// ===== src/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: stream ports, output register,
// sequencer and slot memory. Depends on spq_pkg, spq_store and spq_seq.
//
// Channel  Dir  Signals                       Fields (lowest bit up)
// s_       in   s_tvalid s_tready s_tdata     data_value[31:0] priority_req[39:32]
//                s_tuser                      req_type[0]
// m_       out  m_tvalid m_tready m_tdata     data_out[31:0]
//                m_tuser                      status[1:0]
//
// One request at a time: s_tready is high only while the sequencer is idle.
// Enqueue walks down from the top held slot, one read/compare pair per slot moved up,
// then writes the new entry; dequeue reads every held entry, returns slot 0 and moves
// the rest down a slot; full or empty answers need no memory access. The pace of each
// walk is set by the registered read of the slot memory.
// Reset (aresetn low, synchronous) empties the queue; slot contents are not cleared.
// A finished result waits in the output register; the next request is accepted
// meanwhile, and its own result waits in the sequencer until m_tready frees the register.
`timescale 1ns / 1ps

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_value[31:0], priority_req[39:32]
    input  logic        s_tuser,   // req_type[0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // data_out[31:0]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int AW = $clog2(DEPTH);

    logic          start;
    logic          seq_idle;
    logic          out_free;
    logic          res_valid;
    spq_req_t      req;
    spq_result_t   res;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_entry;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_entry;

    logic              m_valid_reg;
    status_t           m_status_reg;
    logic [DATA_W-1:0] m_data_reg;

    // Input transfer
    assign s_tready = seq_idle;
    assign start    = s_tvalid && s_tready;
    assign req      = '{kind: req_t'(s_tuser),
                        data: s_tdata[DATA_W-1:0],
                        prio: s_tdata[DATA_W+PRIO_W-1:DATA_W]};

    spq_seq #(
        .DEPTH(DEPTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .req       (req),
        .idle      (seq_idle),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_entry  (wr_entry),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_entry  (rd_entry)
    );

    spq_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    // Output register
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid) begin
            m_status_reg <= res.status;
            m_data_reg   <= res.data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

endmodule

// ===== src/spq_store.sv =====
// Slot memory of the sorted priority queue: one write and one registered read per cycle.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_store
    import spq_pkg::*;
#(
    parameter int  DEPTH = SPQ_DEPTH,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_entry,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_entry
);

    entry_t mem [DEPTH];
    entry_t rd_entry_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

// ===== src/spq_seq.sv =====
// Sequencer of the sorted priority queue: walks the slot memory one slot per
// read/compare pair, shifting entries for insert and removal. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_seq
    import spq_pkg::*;
#(
    parameter int  DEPTH = SPQ_DEPTH,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    // request side
    input  logic          start,
    input  spq_req_t      req,
    output logic          idle,
    // result side
    input  logic          out_free,
    output logic          res_valid,
    output spq_result_t   res,
    // slot memory
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output entry_t        wr_entry,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  entry_t        rd_entry
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_PUT,
        S_DONE
    } state_t;

    state_t            state_reg,  state_next;
    logic [AW-1:0]     idx_reg,    idx_next;
    logic [CW-1:0]     cnt_reg,    cnt_next;
    spq_req_t          req_reg,    req_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] dout_reg,   dout_next;

    entry_t new_entry;
    logic   last_slot;

    assign new_entry = '{prio: req_reg.prio, data: req_reg.data};
    // dequeue walk ends at the top held slot
    assign last_slot = (CW'(idx_reg) + CW'(1)) == cnt_reg;

    // Next-state and memory control
    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        req_next    = req_reg;
        status_next = status_reg;
        dout_next   = dout_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_entry    = new_entry;
        rd_en       = 1'b0;
        rd_addr     = idx_reg;
        res_valid   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    req_next    = req;
                    status_next = ST_OK;
                    dout_next   = '0;
                    if (req.kind == REQ_ENQ) begin
                        if (cnt_reg == CW'(DEPTH)) begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end else if (cnt_reg == '0) begin
                            idx_next   = '0;
                            state_next = S_PUT;
                        end else begin
                            // start from the top held slot and walk down
                            idx_next   = AW'(cnt_reg - CW'(1));
                            state_next = S_RD;
                        end
                    end else begin
                        if (cnt_reg == '0) begin
                            status_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end else begin
                            idx_next   = '0;
                            state_next = S_RD;
                        end
                    end
                end
            end

            S_RD: begin
                rd_en      = 1'b1;
                state_next = S_WR;
            end

            S_WR: begin
                if (req_reg.kind == REQ_ENQ) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(idx_reg + AW'(1));
                    if (rd_entry.prio > req_reg.prio) begin
                        // held slot moves up one place
                        wr_entry = rd_entry;
                        if (idx_reg == '0) begin
                            state_next = S_PUT;
                        end else begin
                            idx_next   = AW'(idx_reg - AW'(1));
                            state_next = S_RD;
                        end
                    end else begin
                        // insert behind equal or lower priority numbers
                        wr_entry   = new_entry;
                        cnt_next   = CW'(cnt_reg + CW'(1));
                        state_next = S_DONE;
                    end
                end else begin
                    if (idx_reg == '0) begin
                        dout_next = rd_entry.data;
                    end else begin
                        wr_en    = 1'b1;
                        wr_addr  = AW'(idx_reg - AW'(1));
                        wr_entry = rd_entry;
                    end
                    if (last_slot) begin
                        cnt_next   = CW'(cnt_reg - CW'(1));
                        state_next = S_DONE;
                    end else begin
                        idx_next   = AW'(idx_reg + AW'(1));
                        state_next = S_RD;
                    end
                end
            end

            S_PUT: begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_entry   = new_entry;
                cnt_next   = CW'(cnt_reg + CW'(1));
                state_next = S_DONE;
            end

            S_DONE: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        idx_reg    <= idx_next;
        req_reg    <= req_next;
        status_reg <= status_next;
        dout_reg   <= dout_next;
    end

    assign idle = (state_reg == S_IDLE);
    assign res  = '{status: status_reg, data: dout_reg};

    // Checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("slot count above depth");

    a_full_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.status == ST_FULL |-> cnt_reg == CW'(DEPTH))
        else $error("full status with free slots");

    a_empty_only_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.status == ST_EMPTY |-> cnt_reg == '0 && res.data == '0)
        else $error("empty status with held entries or nonzero data");

    a_start_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start && idle |=> !idle)
        else $error("request taken but sequencer stayed idle");

    a_enq_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && req_reg.kind == REQ_ENQ |-> res.data == '0)
        else $error("enqueue result carries data");

endmodule

// ===== test/tb_sorted_priority_queue.sv =====
// Self-checking testbench for sorted_priority_queue: a directed table, then random
// enqueue/dequeue traffic checked against a behavioral sorted-store predictor.
// Depends on spq_pkg and sorted_priority_queue.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int QDEPTH      = SPQ_DEPTH;
    localparam int RAND_ITEMS  = 1930;
    localparam int CALM_ITEMS  = 200;    // tail of the run without idling
    localparam int HOLD_AFTER  = 600;    // transfers before the long output stall
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 40;

    // One row of the directed table; want is used only when typed is set
    typedef struct packed {
        req_t              kind;
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
        logic              typed;
        spq_result_t       want;
    } plan_row_t;

    localparam int PLAN_LEN = 23;
    localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
        // dequeue right after reset, ignored fields all ones
        '{REQ_DEQ, 32'hFFFF_FFFF, 8'hFF, 1'b1, '{ST_EMPTY, 32'h0}},
        '{REQ_ENQ, 32'h7FFF_FFFF, 8'hFF, 1'b1, '{ST_OK, 32'h0}},
        '{REQ_ENQ, 32'h8000_0000, 8'h00, 1'b1, '{ST_OK, 32'h0}},
        '{REQ_ENQ, 32'h0000_0000, 8'h80, 1'b0, '{ST_OK, 32'h0}},
        // equal priorities keep arrival order
        '{REQ_ENQ, 32'hFFFF_FFFF, 8'h80, 1'b0, '{ST_OK, 32'h0}},
        '{REQ_ENQ, 32'h1234_5678, 8'h80, 1'b0, '{ST_OK, 32'h0}},
        '{REQ_ENQ, 32'hA5A5_A5A5, 8'hFF, 1'b0, '{ST_OK, 32'h0}},
        '{REQ_ENQ, 32'h5A5A_5A5A, 8'h00, 1'b0, '{ST_OK, 32'h0}},
        '{REQ_ENQ, 32'h0000_0001, 8'h01, 1'b0, '{ST_OK, 32'h0}},
        // queue now full: enqueues are dropped
        '{REQ_ENQ, 32'hDEAD_BEEF, 8'h00, 1'b1, '{ST_FULL, 32'h0}},
        '{REQ_ENQ, 32'h0000_0000, 8'hFF, 1'b1, '{ST_FULL, 32'h0}},
        // smallest priority number, first arrival, leaves first
        '{REQ_DEQ, 32'h0000_0000, 8'h00, 1'b1, '{ST_OK, 32'h8000_0000}},
        '{REQ_DEQ, 32'h0000_0000, 8'h00, 1'b0, '{ST_OK, 32'h0}},
        '{REQ_DEQ, 32'hFFFF_FFFF, 8'hFF, 1'b0, '{ST_OK, 32'h0}},
        '{REQ_DEQ, 32'h0000_0000, 8'h00, 1'b0, '{ST_OK, 32'h0}},
        '{REQ_DEQ, 32'h5555_5555, 8'h55, 1'b0, '{ST_OK, 32'h0}},
        '{REQ_DEQ, 32'hAAAA_AAAA, 8'hAA, 1'b0, '{ST_OK, 32'h0}},
        '{REQ_DEQ, 32'h0000_0000, 8'h00, 1'b0, '{ST_OK, 32'h0}},
        '{REQ_DEQ, 32'h0000_0000, 8'h00, 1'b0, '{ST_OK, 32'h0}},
        // drained again
        '{REQ_DEQ, 32'h0000_0000, 8'h00, 1'b1, '{ST_EMPTY, 32'h0}},
        '{REQ_DEQ, 32'hFFFF_FFFF, 8'hFF, 1'b1, '{ST_EMPTY, 32'h0}},
        '{REQ_ENQ, 32'hFFFF_FFFF, 8'h00, 1'b0, '{ST_OK, 32'h0}},
        '{REQ_DEQ, 32'h0000_0000, 8'h00, 1'b0, '{ST_OK, 32'h0}}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // data_value[31:0], priority_req[39:32]
    logic        s_tuser;   // req_type[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // data_out[31:0]
    logic [1:0]  m_tuser;   // status[1:0]

    // Side info that travels with each request: a typed-in answer, if any
    logic        row_typed;
    spq_result_t row_want;

    // Shadow copy of the sorted store
    logic [DATA_W-1:0] shadow_data [QDEPTH];
    logic [PRIO_W-1:0] shadow_prio [QDEPTH];
    int                shadow_count;

    spq_result_t pending_answers [$];
    int          err_count;
    int          n_accepted;
    logic        calm;

    sorted_priority_queue #(.DEPTH(QDEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Sorted insert after equal priorities, or pop of slot 0
    function automatic spq_result_t ordered_step(req_t kind, logic [DATA_W-1:0] value,
                                                 logic [PRIO_W-1:0] prio);
        spq_result_t ans;
        int          pos;
        int          k;
        ans.status = ST_OK;
        ans.data   = '0;
        if (kind == REQ_ENQ) begin
            if (shadow_count >= QDEPTH) begin
                ans.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] <= prio) pos++;
                for (k = shadow_count; k > pos; k--) begin
                    shadow_data[k] = shadow_data[k-1];
                    shadow_prio[k] = shadow_prio[k-1];
                end
                shadow_data[pos] = value;
                shadow_prio[pos] = prio;
                shadow_count++;
            end
        end else if (shadow_count == 0) begin
            ans.status = ST_EMPTY;
        end else begin
            ans.data = shadow_data[0];
            for (k = 1; k < shadow_count; k++) begin
                shadow_data[k-1] = shadow_data[k];
                shadow_prio[k-1] = shadow_prio[k];
            end
            shadow_count--;
        end
        return ans;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        err_count++;
    endtask

    // Offer one request and hold it until the transfer
    task automatic send_request(req_t kind, logic [DATA_W-1:0] value,
                                logic [PRIO_W-1:0] prio, logic typed,
                                spq_result_t want, bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= kind;
        s_tdata   <= {prio, value};
        row_typed <= typed;
        row_want  <= want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Predict on every request transfer, check every result transfer
    always @(posedge aclk) begin : watch
        spq_result_t ans;
        spq_result_t exp_ans;
        if (aresetn && s_tvalid && s_tready) begin
            ans = ordered_step(req_t'(s_tuser), s_tdata[31:0], s_tdata[39:32]);
            if (row_typed) ans = row_want;
            pending_answers.push_back(ans);
            n_accepted++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result", {30'b0, m_tuser}, 32'h0);
            end else begin
                exp_ans = pending_answers.pop_front();
                if (m_tuser !== exp_ans.status)
                    report_mismatch("status", {30'b0, m_tuser}, {30'b0, exp_ans.status});
                if (m_tdata !== exp_ans.data)
                    report_mismatch("data_out", m_tdata, exp_ans.data);
            end
        end
    end

    // Result side: random ready bursts, one long stall, always ready at the end
    initial begin : receiver
        int  n;
        int  c;
        bit  held;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if (!held && n_accepted >= HOLD_AFTER) begin
                m_tready <= 1'b0;
                for (c = 0; c < HOLD_CYCLES; c++) @(posedge aclk);
                held = 1'b1;
            end else if ($urandom_range(0, 2) != 0) begin
                n = $urandom_range(1, 30);
                m_tready <= 1'b1;
                repeat (n) @(posedge aclk);
            end else begin
                n = $urandom_range(1, 18);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    // Request side: directed table, then phased random traffic
    initial begin : sender
        int          i;
        int          sent;
        int          plen;
        int          enq_pct;
        int          prio_mode;
        req_t        kind;
        logic [7:0]  prio;
        spq_result_t none;
        err_count    = 0;
        n_accepted   = 0;
        shadow_count = 0;
        none         = '{ST_OK, 32'h0};
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_ENQ;
        row_typed <= 1'b0;
        row_want  <= none;
        calm      <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < PLAN_LEN; i++) begin
            send_request(PLAN[i].kind, PLAN[i].data, PLAN[i].prio, PLAN[i].typed,
                         PLAN[i].want, 1'b1);
        end

        // Phases lean toward filling, draining or hovering; priority spread varies
        sent = 0;
        while (sent < RAND_ITEMS) begin
            plen = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
                0: enq_pct = 15;
                1: enq_pct = 50;
                default: enq_pct = 85;
            endcase
            prio_mode = $urandom_range(0, 2);
            for (i = 0; i < plen && sent < RAND_ITEMS; i++) begin
                if (sent == RAND_ITEMS - CALM_ITEMS) calm <= 1'b1;
                kind = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
                case (prio_mode)
                    0: prio = 8'($urandom);
                    1: prio = 8'($urandom_range(0, 3));
                    default: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                endcase
                send_request(kind, $urandom, prio, 1'b0, none,
                             sent < RAND_ITEMS - CALM_ITEMS);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then wait for any stray result
        @(posedge aclk);
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (pending_answers.size() != 0)
            report_mismatch("results missing", pending_answers.size(), 32'h0);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
